/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of the stroke generator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DVSG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define DVSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/dvsg_pkg.sv */
// Shared types, constants, glyph tables and constant dividers of the
// decimal vector stroke generator. No dependencies.
`default_nettype none
package dvsg_pkg;

  localparam int MAX_DIGITS_DEF = 5;
  localparam int COORD_W        = 13;
  localparam int MAG_W          = 17;
  localparam int IN_DATA_W      = 48;
  localparam int OUT_DATA_W     = 56;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MINUS,
    S_DSTART,
    S_DWAIT,
    S_SEG
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
  } du_ctrl_t;

  typedef struct packed {
    logic       done;
    logic [3:0] digit;
  } du_stat_t;

  typedef struct packed {
    logic [1:0] x0;
    logic [2:0] y0;
    logic [1:0] x1;
    logic [2:0] y1;
  } seg_code_t;

  localparam logic [3:0] SEG_COUNT [10] = '{
    4'd8, 4'd4, 4'd12, 4'd12, 4'd10, 4'd12, 4'd12, 4'd6, 4'd12, 4'd12
  };

  localparam seg_code_t GLYPH [10][12] = '{
    '{'{0,0,3,0},'{3,0,3,5},'{3,5,0,5},'{0,5,0,0},'{1,1,2,1},'{2,1,2,4},
      '{2,4,1,4},'{1,4,1,1},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0}},
    '{'{0,0,3,0},'{3,0,3,5},'{3,5,0,5},'{0,5,0,0},'{0,0,0,0},'{0,0,0,0},
      '{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0}},
    '{'{0,0,3,0},'{3,0,3,3},'{3,3,1,3},'{1,3,1,4},'{1,4,3,4},'{3,4,3,5},
      '{3,5,0,5},'{0,5,0,2},'{0,2,2,2},'{2,2,2,1},'{2,1,0,1},'{0,1,0,0}},
    '{'{0,0,3,0},'{3,0,3,5},'{3,5,0,5},'{0,5,0,4},'{0,4,2,4},'{2,4,2,3},
      '{2,3,0,3},'{0,3,0,2},'{0,2,2,2},'{2,2,2,1},'{2,1,0,1},'{0,1,0,0}},
    '{'{0,0,1,0},'{1,0,1,2},'{1,2,2,2},'{2,2,2,0},'{2,0,3,0},'{3,0,3,5},
      '{3,5,2,5},'{2,5,2,3},'{2,3,0,3},'{0,3,0,0},'{0,0,0,0},'{0,0,0,0}},
    '{'{0,0,3,0},'{3,0,3,1},'{3,1,1,1},'{1,1,1,2},'{1,2,3,2},'{3,2,3,5},
      '{3,5,0,5},'{0,5,0,4},'{0,4,2,4},'{2,4,2,3},'{2,3,0,3},'{0,3,0,0}},
    '{'{0,0,3,0},'{3,0,3,1},'{3,1,1,1},'{1,1,1,2},'{1,2,3,2},'{3,2,3,5},
      '{3,5,0,5},'{0,5,0,0},'{1,3,2,3},'{2,3,2,4},'{2,4,1,4},'{1,4,1,3}},
    '{'{0,0,3,0},'{3,0,3,5},'{3,5,2,5},'{2,5,2,1},'{2,1,0,1},'{0,1,0,0},
      '{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0},'{0,0,0,0}},
    '{'{0,0,3,0},'{3,0,3,5},'{3,5,0,5},'{0,5,0,0},'{1,1,2,1},'{2,1,2,2},
      '{2,2,1,2},'{1,2,1,1},'{1,3,2,3},'{2,3,2,4},'{2,4,1,4},'{1,4,1,3}},
    '{'{0,0,3,0},'{3,0,3,5},'{3,5,0,5},'{0,5,0,4},'{0,4,2,4},'{2,4,2,3},
      '{2,3,0,3},'{0,3,0,0},'{1,1,2,1},'{2,1,2,2},'{2,2,1,2},'{1,2,1,1}}
  };

  // 10**n for n in 0..5
  function automatic logic [MAG_W-1:0] pow10(input int n);
    logic [MAG_W-1:0] p;
    p = MAG_W'(1);
    for (int i = 0; i < 5; i++) begin
      if (i < n) begin
        p = MAG_W'(p * MAG_W'(10));
      end
    end
    return p;
  endfunction

  // floor(v/3), exact for every 10-bit v
  function automatic logic [9:0] div3(input logic [9:0] v);
    logic [20:0] prod;
    prod = 21'(v) * 21'(683);
    return prod[20:11];
  endfunction

  // floor(v/5), exact for v < 4096
  function automatic logic [9:0] div5(input logic [11:0] v);
    logic [23:0] prod;
    prod = 24'(v) * 24'(3277);
    return prod[23:14];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/dvsg_digit_unit.sv */
// Shared subtract/compare unit: extracts one decimal digit of the held
// magnitude per run, one trial subtraction a cycle. Depends on dvsg_pkg.
`default_nettype none
module dvsg_digit_unit #(
  parameter int POS_W = 3
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire dvsg_pkg::du_ctrl_t           ctrl,
  input  wire logic [dvsg_pkg::MAG_W-1:0]   load_mag,
  input  wire logic [POS_W-1:0]             pos,
  output dvsg_pkg::du_stat_t                stat
);

  logic [dvsg_pkg::MAG_W-1:0] mag_r;
  logic [3:0]                 digit_r;
  logic [1:0]                 bit_r;
  logic                       busy_r;
  logic                       done_r;
  logic [dvsg_pkg::MAG_W-1:0] pow;
  logic [dvsg_pkg::MAG_W:0]   trial;

  assign pow   = dvsg_pkg::pow10(int'(pos));
  assign trial = {1'b0, mag_r} - ({1'b0, pow} << bit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == 2'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag_r <= load_mag;
    end else if (busy_r && !trial[dvsg_pkg::MAG_W]) begin
      mag_r <= trial[dvsg_pkg::MAG_W-1:0];
    end
    if (ctrl.start) begin
      digit_r <= 4'd0;
      bit_r   <= 2'd3;
    end else if (busy_r) begin
      if (!trial[dvsg_pkg::MAG_W]) begin
        digit_r[bit_r] <= 1'b1;
      end
      bit_r <= bit_r - 2'd1;
    end
  end

  assign stat.done  = done_r;
  assign stat.digit = digit_r;

endmodule
`default_nettype wire

/* hw/rtl/decimal_vector_stroke_generator.sv */
// Top level of the decimal vector stroke generator: sequencer, glyph
// scaling and output register. Depends on dvsg_pkg and dvsg_digit_unit.
//
// Takes one item (origin, glyph height, signed 16-bit value) and emits the
// outline segments of its decimal glyphs, one segment per output item, most
// significant digit first, with tlast on the final segment. A negative value
// first gets a fixed five-unit minus stroke and the origin moves right by 10.
// Zero gives the zero glyph alone. Magnitudes beyond MAX_DIGITS digits
// saturate to the largest MAX_DIGITS-digit number. in_tready is high only
// while the block is idle, so it takes no new item while one is in progress.
// It emits the minus stroke for a negative value, then for each digit
// position from the top extracts the digit through the shared subtract unit
// (four trial subtractions plus handoff) and, past leading zeros, emits its
// segments, one per cycle while the output is not stalled. The output
// register lets the last segment wait while the next item is accepted.
`default_nettype none
module decimal_vector_stroke_generator #(
  parameter int MAX_DIGITS = dvsg_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // x_pos[10:0], y_pos[21:11], height[31:22], value[47:32]
  input  wire logic [dvsg_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // start_x[12:0], start_y[25:13], end_x[38:26], end_y[51:39], zero pad
  output logic [dvsg_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                   out_tlast
);

  localparam int POS_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [dvsg_pkg::MAG_W-1:0] LIMIT =
    dvsg_pkg::MAG_W'(dvsg_pkg::pow10(MAX_DIGITS) - 1);
  localparam logic [POS_W-1:0] TOP_POS = POS_W'(MAX_DIGITS - 1);
  localparam int CW = dvsg_pkg::COORD_W;

  dvsg_pkg::state_t state_r, state_nxt;

  // Per-item geometry, captured at accept
  logic [CW-1:0] x_r;
  logic [10:0]   y_r;
  logic [9:0]    h_r;
  logic [9:0]    yo_r [4];   // h/5, 2h/5, 3h/5, 4h/5
  logic [8:0]    w2_r, w2a_r, w2b_r;  // w, w/3, 2w/3 for w = h/2
  logic [8:0]    w4_r, w4a_r, w4b_r;  // same for w = h/4 (digit one)
  logic [9:0]    adv_r;
  logic [POS_W-1:0] pos_r;
  logic          started_r;
  logic [3:0]    digit_r;
  logic [3:0]    seg_r;

  logic                          out_valid_r;
  logic [dvsg_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                          out_last_r;

  dvsg_pkg::du_ctrl_t du_ctrl;
  dvsg_pkg::du_stat_t du_stat;

  // Input decode
  logic [9:0]  h_in;
  logic [9:0]  w2_in, w4_in;
  logic [15:0] v_in;
  logic [dvsg_pkg::MAG_W-1:0] mag_in, mag_sat;
  logic [11:0] h3_in;
  logic [11:0] adv_full;
  logic        accept;

  assign h_in   = in_tdata[31:22];
  assign v_in   = in_tdata[47:32];
  assign w2_in  = {1'b0, h_in[9:1]};
  assign w4_in  = {2'b0, h_in[9:2]};
  assign h3_in  = 12'({2'b0, h_in} + {1'b0, h_in, 1'b0});
  assign adv_full = 12'({w2_in, 2'b0} + {2'b0, w2_in});
  assign mag_in = v_in[15] ? dvsg_pkg::MAG_W'(17'h10000 - {1'b0, v_in})
                           : {1'b0, v_in};
  assign mag_sat = (mag_in > LIMIT) ? LIMIT : mag_in;
  assign accept  = in_tvalid && in_tready;

  // Segment geometry
  dvsg_pkg::seg_code_t code;
  logic          is_one;
  logic          can_load;
  logic          seg_end;
  logic          emit;
  logic          lead_zero;
  logic [CW-1:0] sx, sy, ex, ey;

  function automatic logic [8:0] xsel(input logic [1:0] c, input logic one,
                                      input logic [8:0] a2, input logic [8:0] b2,
                                      input logic [8:0] f2, input logic [8:0] a4,
                                      input logic [8:0] b4, input logic [8:0] f4);
    logic [8:0] r;
    case (c)
      2'd1:    r = one ? a4 : a2;
      2'd2:    r = one ? b4 : b2;
      2'd3:    r = one ? f4 : f2;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [9:0] ysel(input logic [2:0] c, input logic [9:0] y1,
                                      input logic [9:0] y2, input logic [9:0] y3,
                                      input logic [9:0] y4, input logic [9:0] hh);
    logic [9:0] r;
    case (c)
      3'd0:    r = 10'd0;
      3'd1:    r = y1;
      3'd2:    r = y2;
      3'd3:    r = y3;
      3'd4:    r = y4;
      default: r = hh;
    endcase
    return r;
  endfunction

  assign code     = dvsg_pkg::GLYPH[digit_r][seg_r];
  assign is_one   = (digit_r == 4'd1);
  assign can_load = !out_valid_r || out_tready;
  assign seg_end  = (4'(seg_r + 4'd1) == dvsg_pkg::SEG_COUNT[digit_r]);
  // Skip leading zeros; the units position always prints
  assign lead_zero = (du_stat.digit == 4'd0) && !started_r && (pos_r != '0);

  assign sx = x_r + CW'(xsel(code.x0, is_one, w2a_r, w2b_r, w2_r,
                             w4a_r, w4b_r, w4_r));
  assign ex = x_r + CW'(xsel(code.x1, is_one, w2a_r, w2b_r, w2_r,
                             w4a_r, w4b_r, w4_r));
  assign sy = CW'(y_r) + CW'(ysel(code.y0, yo_r[0], yo_r[1], yo_r[2],
                                  yo_r[3], h_r));
  assign ey = CW'(y_r) + CW'(ysel(code.y1, yo_r[0], yo_r[1], yo_r[2],
                                  yo_r[3], h_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dvsg_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = v_in[15] ? dvsg_pkg::S_MINUS : dvsg_pkg::S_DSTART;
        end
      end
      dvsg_pkg::S_MINUS: begin
        if (can_load) begin
          state_nxt = dvsg_pkg::S_DSTART;
        end
      end
      dvsg_pkg::S_DSTART: state_nxt = dvsg_pkg::S_DWAIT;
      dvsg_pkg::S_DWAIT: begin
        if (du_stat.done) begin
          state_nxt = lead_zero ? dvsg_pkg::S_DSTART : dvsg_pkg::S_SEG;
        end
      end
      dvsg_pkg::S_SEG: begin
        if (can_load && seg_end) begin
          state_nxt = (pos_r == '0) ? dvsg_pkg::S_IDLE : dvsg_pkg::S_DSTART;
        end
      end
      default: state_nxt = dvsg_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready     = 1'b0;
    emit          = 1'b0;
    du_ctrl.load  = 1'b0;
    du_ctrl.start = 1'b0;
    case (state_r)
      dvsg_pkg::S_IDLE: begin
        in_tready    = 1'b1;
        du_ctrl.load = in_tvalid;
      end
      dvsg_pkg::S_MINUS:  emit = can_load;
      dvsg_pkg::S_DSTART: du_ctrl.start = 1'b1;
      dvsg_pkg::S_SEG:    emit = can_load;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  dvsg_digit_unit #(
    .POS_W (POS_W)
  ) u_digit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (du_ctrl),
    .load_mag (mag_sat),
    .pos      (pos_r),
    .stat     (du_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dvsg_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r       <= CW'(in_tdata[10:0]);
      y_r       <= in_tdata[21:11];
      h_r       <= h_in;
      yo_r[0]   <= dvsg_pkg::div5({2'b0, h_in});
      yo_r[1]   <= dvsg_pkg::div5({1'b0, h_in, 1'b0});
      yo_r[2]   <= dvsg_pkg::div5(h3_in);
      yo_r[3]   <= dvsg_pkg::div5({h_in, 2'b0});
      w2_r      <= w2_in[8:0];
      w2a_r     <= 9'(dvsg_pkg::div3(w2_in));
      w2b_r     <= 9'(dvsg_pkg::div3({w2_in[8:0], 1'b0}));
      w4_r      <= w4_in[8:0];
      w4a_r     <= 9'(dvsg_pkg::div3(w4_in));
      w4b_r     <= 9'(dvsg_pkg::div3({w4_in[8:0], 1'b0}));
      adv_r     <= adv_full[11:2];
      // Skip zeros until the first nonzero digit; zero prints at the units
      started_r <= 1'b0;
      pos_r     <= TOP_POS;
    end else begin
      case (state_r)
        dvsg_pkg::S_MINUS: begin
          if (can_load) begin
            x_r <= x_r + CW'(10);
          end
        end
        dvsg_pkg::S_DWAIT: begin
          if (du_stat.done) begin
            if (lead_zero) begin
              pos_r <= pos_r - POS_W'(1);
            end else begin
              started_r <= 1'b1;
              digit_r   <= du_stat.digit;
              seg_r     <= 4'd0;
            end
          end
        end
        dvsg_pkg::S_SEG: begin
          if (can_load) begin
            if (seg_end) begin
              x_r <= x_r + CW'(adv_r);
              if (pos_r != '0) begin
                pos_r <= pos_r - POS_W'(1);
              end
            end else begin
              seg_r <= seg_r + 4'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: load the minus stroke or the current glyph segment
  always_ff @(posedge clk) begin
    if (emit) begin
      if (state_r == dvsg_pkg::S_MINUS) begin
        out_data_r <= {4'd0, CW'(y_r) + CW'(5), x_r + CW'(5),
                       CW'(y_r) + CW'(5), x_r};
        out_last_r <= 1'b0;
      end else begin
        out_data_r <= {4'd0, ey, ex, sy, sx};
        out_last_r <= seg_end && (pos_r == '0);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

/* hw/rtl/dvsg_checker.sv */
// Port-level checker for the stroke generator, bound to the top level.
// Depends on assert_macros.svh and dvsg_pkg.
`default_nettype none
`include "assert_macros.svh"
module dvsg_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [dvsg_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           out_tlast
);

  // A stalled output item holds
  `DVSG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // An accepted item keeps the block busy for at least the next cycle
  `DVSG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // Pad bits above the four coordinates stay zero
  `DVSG_ASSERT_IMPL(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[55:52] == 4'd0)

endmodule

bind decimal_vector_stroke_generator dvsg_checker u_dvsg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

/* bench/tb_decimal_vector_stroke_generator.sv */
// Self-checking bench for decimal_vector_stroke_generator: drives numbers
// into the stream input and compares every emitted segment with a predictor.
// Depends on dvsg_pkg and the RTL of the block.
`timescale 1ns / 100ps
module tb_decimal_vector_stroke_generator;

  localparam int LIMIT_CYCLES = 2_000_000;

  typedef struct packed {
    logic [12:0] sx;
    logic [12:0] sy;
    logic [12:0] ex;
    logic [12:0] ey;
    logic        last;
  } segment_t;

  // One row of the directed table; check_first marks a typed-in first segment.
  typedef struct {
    logic [10:0] x;
    logic [10:0] y;
    logic [9:0]  h;
    logic [15:0] v;
    bit          check_first;
    segment_t    first_seg;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;

  segment_t    segments_due[$];
  int          errors;
  int          cycles;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  bit          first_seg_pending;
  segment_t    first_seg_typed;

  decimal_vector_stroke_generator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Glyph tables, kept locally so the prediction is independent of the RTL.
  function automatic int glyph_segs(input int d);
    int cnt [10] = '{8, 4, 12, 12, 10, 12, 12, 6, 12, 12};
    return cnt[d];
  endfunction

  function automatic logic [11:0] glyph_code(input int d, input int i);
    // packed as x0[11:9] y0[8:6] x1[5:3] y1[2:0]
    logic [11:0] g [10][12] = '{
      '{12'o0030, 12'o3035, 12'o3505, 12'o0500, 12'o1121, 12'o2124,
        12'o2414, 12'o1411, 0, 0, 0, 0},
      '{12'o0030, 12'o3035, 12'o3505, 12'o0500, 0, 0, 0, 0, 0, 0, 0, 0},
      '{12'o0030, 12'o3033, 12'o3313, 12'o1314, 12'o1434, 12'o3435,
        12'o3505, 12'o0502, 12'o0222, 12'o2221, 12'o2101, 12'o0100},
      '{12'o0030, 12'o3035, 12'o3505, 12'o0504, 12'o0424, 12'o2423,
        12'o2303, 12'o0302, 12'o0222, 12'o2221, 12'o2101, 12'o0100},
      '{12'o0010, 12'o1012, 12'o1222, 12'o2220, 12'o2030, 12'o3035,
        12'o3525, 12'o2523, 12'o2303, 12'o0300, 0, 0},
      '{12'o0030, 12'o3031, 12'o3111, 12'o1112, 12'o1232, 12'o3235,
        12'o3505, 12'o0504, 12'o0424, 12'o2423, 12'o2303, 12'o0300},
      '{12'o0030, 12'o3031, 12'o3111, 12'o1112, 12'o1232, 12'o3235,
        12'o3505, 12'o0500, 12'o1323, 12'o2324, 12'o2414, 12'o1413},
      '{12'o0030, 12'o3035, 12'o3525, 12'o2521, 12'o2101, 12'o0100,
        0, 0, 0, 0, 0, 0},
      '{12'o0030, 12'o3035, 12'o3505, 12'o0500, 12'o1121, 12'o2122,
        12'o2212, 12'o1211, 12'o1323, 12'o2324, 12'o2414, 12'o1413},
      '{12'o0030, 12'o3035, 12'o3505, 12'o0504, 12'o0424, 12'o2423,
        12'o2303, 12'o0300, 12'o1121, 12'o2122, 12'o2212, 12'o1211}
    };
    return g[d][i];
  endfunction

  function automatic int col_offset(input int code, input int w);
    case (code)
      1: return w / 3;
      2: return (w * 2) / 3;
      3: return w;
      default: return 0;
    endcase
  endfunction

  function automatic int row_offset(input int code, input int h);
    return (code >= 5) ? h : (h * code) / 5;
  endfunction

  task automatic queue_glyph(input int d, input int x, input int y, input int h);
    int w;
    logic [11:0] c;
    segment_t s;
    w = (d == 1) ? h / 4 : h / 2;
    for (int i = 0; i < glyph_segs(d); i++) begin
      c = glyph_code(d, i);
      s.sx = 13'(x + col_offset(c[11:9], w));
      s.sy = 13'(y + row_offset(c[8:6], h));
      s.ex = 13'(x + col_offset(c[5:3], w));
      s.ey = 13'(y + row_offset(c[2:0], h));
      s.last = 1'b0;
      segments_due.push_back(s);
    end
  endtask

  // Predict the whole outline of one number and append it to the queue.
  task automatic predict_outline(input logic [10:0] x_in, input logic [10:0] y_in,
                                 input logic [9:0] h_in, input logic [15:0] v_in);
    int x, y, h, mag, lim, nd, adv;
    int digs [5];
    segment_t s;
    x = x_in; y = y_in; h = h_in; nd = 0;
    if (v_in == 16'd0) begin
      queue_glyph(0, x, y, h);
    end else begin
      if (v_in[15]) begin
        mag = 65536 - int'(v_in);
        s.sx = 13'(x); s.sy = 13'(y + 5); s.ex = 13'(x + 5); s.ey = 13'(y + 5);
        s.last = 1'b0;
        segments_due.push_back(s);
        x += 10;
      end else begin
        mag = v_in;
      end
      lim = 1;
      for (int i = 0; i < dvsg_pkg::MAX_DIGITS_DEF; i++) lim *= 10;
      if (mag > lim - 1) mag = lim - 1;
      while (mag != 0 && nd < dvsg_pkg::MAX_DIGITS_DEF) begin
        digs[nd++] = mag % 10;
        mag /= 10;
      end
      adv = ((h / 2) * 5) / 4;
      for (int i = nd - 1; i >= 0; i--) begin
        queue_glyph(digs[i], x, y, h);
        x += adv;
      end
    end
    segments_due[$].last = 1'b1;
  endtask

  // Offer one number and hold it until the block takes it.
  task automatic send_number(input logic [10:0] x, input logic [10:0] y,
                             input logic [9:0] h, input logic [15:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v, h, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_outline(x, y, h, v);
  endtask

  // Drop the input and wait until every expected segment has come.
  task automatic drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (segments_due.size() != 0);
  endtask

  // Random numbers: mostly small heights, all value ranges.
  task automatic send_random(input int n);
    logic [15:0] v;
    logic [9:0]  h;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: v = 16'($urandom_range(9));
        1: v = 16'(-$urandom_range(99));
        2: v = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        default: v = 16'($urandom);
      endcase
      h = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(63));
      send_number(11'($urandom), 11'($urandom), h, v);
    end
  endtask

  // Receiver: stall at random, check each accepted segment in order.
  always @(posedge clk) begin
    segment_t got, want;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[12:0], out_tdata[25:13], out_tdata[38:26],
               out_tdata[51:39], out_tlast};
        if (segments_due.size() == 0) begin
          $error("segment with nothing expected: %p", got);
          errors++;
        end else begin
          want = segments_due.pop_front();
          if (first_seg_pending) begin
            // typed-in row must agree with the predictor too
            if (first_seg_typed !== want) begin
              $error("table row first segment: expected %p predicted %p",
                     first_seg_typed, want);
              errors++;
            end
            first_seg_pending = 1'b0;
          end
          if (got.sx !== want.sx) begin
            $error("start_x expected %0d actual %0d", want.sx, got.sx); errors++;
          end
          if (got.sy !== want.sy) begin
            $error("start_y expected %0d actual %0d", want.sy, got.sy); errors++;
          end
          if (got.ex !== want.ex) begin
            $error("end_x expected %0d actual %0d", want.ex, got.ex); errors++;
          end
          if (got.ey !== want.ey) begin
            $error("end_y expected %0d actual %0d", want.ey, got.ey); errors++;
          end
          if (got.last !== want.last) begin
            $error("last_segment expected %0d actual %0d", want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("decimal_vector_stroke_generator verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t r;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    errors = 0; cycles = 0; sender_idle_pct = 0; receiver_stall_pct = 0;
    first_seg_pending = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: zero, minus, most negative, largest, every digit,
    // extreme origins and heights. First segments typed in where obvious.
    r = '{0, 0, 0, 16'd0, 1, '{0, 0, 0, 0, 0}}; rows.push_back(r);
    r = '{11'd2047, 11'd2047, 10'd1023, 16'd0, 1,
          '{13'd2047, 13'd2047, 13'd2558, 13'd2047, 0}}; rows.push_back(r);
    r = '{0, 0, 0, 16'hFFFF, 1, '{0, 13'd5, 13'd5, 13'd5, 0}}; rows.push_back(r);
    r = '{11'd100, 11'd200, 10'd40, 16'h8000, 1,
          '{13'd100, 13'd205, 13'd105, 13'd205, 0}}; rows.push_back(r);
    r = '{11'd2047, 11'd2047, 10'd1023, 16'h8000, 1,
          '{13'd2047, 13'd2052, 13'd2052, 13'd2052, 0}}; rows.push_back(r);
    r = '{11'd2047, 11'd2047, 10'd1023, 16'h7FFF, 0, '{default: 0}}; rows.push_back(r);
    for (int d = 1; d <= 9; d++) begin
      r = '{11'd10, 11'd20, 10'd30, 16'(d), 0, '{default: 0}}; rows.push_back(r);
    end
    r = '{11'h555, 11'h2AA, 10'h155, 16'h5555, 0, '{default: 0}}; rows.push_back(r);
    r = '{11'h2AA, 11'h555, 10'h2AA, 16'hAAAA, 0, '{default: 0}}; rows.push_back(r);
    r = '{11'd5, 11'd5, 10'd1, 16'd1234, 0, '{default: 0}}; rows.push_back(r);
    r = '{11'd5, 11'd5, 10'd3, 16'd56789 - 16'd0, 0, '{default: 0}}; rows.push_back(r);
    r = '{11'd0, 11'd0, 10'd7, 16'd10000, 0, '{default: 0}}; rows.push_back(r);

    foreach (rows[i]) begin
      if (rows[i].check_first) begin
        drain;
        first_seg_pending = 1'b1;
        first_seg_typed = rows[i].first_seg;
      end
      send_number(rows[i].x, rows[i].y, rows[i].h, rows[i].v);
    end

    // Random phases with varied idling; one full pause to drain mid-run.
    send_random(110);
    sender_idle_pct = 88;
    send_random(50);
    drain;
    sender_idle_pct = 0; receiver_stall_pct = 88;
    send_random(50);
    sender_idle_pct = 7; receiver_stall_pct = 7;
    send_random(110);
    sender_idle_pct = 0; receiver_stall_pct = 0;
    send_random(90);

    drain;
    repeat (100) @(posedge clk);
    if (errors == 0 && segments_due.size() == 0) begin
      $display("decimal_vector_stroke_generator verification clean");
    end else begin
      $display("decimal_vector_stroke_generator verification failed");
    end
    $finish;
  end
endmodule
